[hdl/sent_pulse_frame_decoder_assert.svh]
// ----------------------------------------------------------------------------
// sent_pulse_frame_decoder assertion macros
// same-cycle and next-cycle implication checks, reset disables them
// ----------------------------------------------------------------------------
`ifndef SENT_PULSE_FRAME_DECODER_ASSERT_SVH
`define SENT_PULSE_FRAME_DECODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SPFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/spfd_pkg.sv]
// ----------------------------------------------------------------------------
// spfd_pkg
// types and constants shared by the sent pulse frame decoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spfd_pkg;

    localparam int PULSE_W   = 16;
    localparam int PERIOD_W  = 11;
    localparam int FRAME_W   = 28;
    localparam int NIB_W     = 4;
    localparam int FRAME_SLOTS = FRAME_W / NIB_W;
    localparam int CODE_W    = 2;
    localparam int DIV_DW    = 17;
    localparam int DIV_CNT_W = $clog2(DIV_DW);
    localparam int CMP_W     = 20;

    localparam logic [PULSE_W-1:0]  IDLE_RESET   = 16'd20000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd120;
    localparam logic [PERIOD_W-1:0] SYNC_TICKS   = 11'd56;

    // sync window and nibble range as exact integer cross products
    localparam logic [CMP_W-1:0] SYNC_HI_MUL = 20'd336;
    localparam logic [CMP_W-1:0] SYNC_LO_MUL = 20'd224;
    localparam logic [CMP_W-1:0] SYNC_FIVE   = 20'd5;
    localparam logic [CMP_W-1:0] RNG_HI_MUL  = 20'd279;
    localparam logic [CMP_W-1:0] RNG_HI_PUL  = 20'd10;
    localparam logic [CMP_W-1:0] RNG_LO_MUL  = 20'd23;
    localparam logic [CMP_W-1:0] RNG_LO_PUL  = 20'd2;

    localparam logic [DIV_DW-1:0] NIB_MAX_Q = 17'd27;
    localparam logic [DIV_DW-1:0] NIB_MIN_Q = 17'd12;
    localparam logic [NIB_W-1:0]  NIB_TOP   = 4'd15;

    localparam logic [CODE_W-1:0] RC_FRAME    = 2'd0;
    localparam logic [CODE_W-1:0] RC_PROGRESS = 2'd1;
    localparam logic [CODE_W-1:0] RC_POST     = 2'd2;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SYNC,
        PH_COLLECT,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_SYNC,
        ACT_NIBBLE,
        ACT_POST
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_RES
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

[hdl/spfd_div.sv]
// ----------------------------------------------------------------------------
// spfd_div
// restoring divider, one quotient bit per cycle, 17 steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spfd_div
    import spfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_DW-1:0]   dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output logic                done,
    output logic [DIV_DW-1:0]   quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [PERIOD_W-1:0]  rem_next;
    logic [DIV_DW-1:0]    quo_reg;
    logic [PERIOD_W-1:0]  dsr_reg;
    logic [PERIOD_W:0]    trial;
    logic [PERIOD_W:0]    diff;
    logic                 q_bit;

    // a zero divisor yields all ones in the quotient
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_DW-1]};
        diff     = trial - {1'b0, dsr_reg};
        q_bit    = (trial >= {1'b0, dsr_reg});
        rem_next = q_bit ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_DW-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/spfd_dp.sv]
// ----------------------------------------------------------------------------
// spfd_dp
// decoder datapath: input latch, window checks, frame state, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spfd_dp
    import spfd_pkg::*;
#(
    parameter int NIBBLES_PER_FRAME = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    input  logic                in_func,
    input  logic [PULSE_W-1:0]  in_pulse,
    input  logic                cfg_we,
    input  logic [PULSE_W-1:0]  cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [CODE_W-1:0]   out_code,
    output logic [FRAME_W-1:0]  out_frame,
    output logic [PERIOD_W-1:0] out_period
);

    localparam int CW = $clog2(NIBBLES_PER_FRAME + 1);
    localparam int IW = $clog2(NIBBLES_PER_FRAME);

    logic                func_reg;
    logic [PULSE_W-1:0]  pulse_reg;
    logic [PULSE_W-1:0]  idle_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [NIB_W-1:0]    store_reg [NIBBLES_PER_FRAME];

    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [CODE_W-1:0]   out_code_next;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic [FRAME_W-1:0]  out_frame_next;
    logic [PERIOD_W-1:0] out_period_reg;

    action_t             action;
    logic [CMP_W-1:0]    p_ext;
    logic [CMP_W-1:0]    t_ext;
    logic                sync_ok;
    logic                reject;
    logic [DIV_DW-1:0]   div_dividend;
    logic [PERIOD_W-1:0] div_divisor;
    logic                div_done;
    logic [DIV_DW-1:0]   div_quo;
    logic [NIB_W-1:0]    nib;
    logic [IW-1:0]       idx;
    logic [CW-1:0]       idx_inc;
    logic [FRAME_W-1:0]  packed_frame;

    // window checks on the latched pulse
    always_comb
    begin
        p_ext   = CMP_W'(pulse_reg);
        t_ext   = CMP_W'(period_reg);
        sync_ok = (p_ext * SYNC_FIVE + SYNC_FIVE <= t_ext * SYNC_HI_MUL)
               && (t_ext * SYNC_LO_MUL + SYNC_FIVE <= p_ext * SYNC_FIVE);
        reject  = (p_ext * RNG_HI_PUL > t_ext * RNG_HI_MUL)
               || (p_ext * RNG_LO_PUL < t_ext * RNG_LO_MUL);
    end

    always_comb
    begin
        if (func_reg || (pulse_reg > idle_reg))
            action = ACT_CLEAR;
        else
        begin
            case (phase_reg)
                PH_SEARCH:  action = sync_ok ? ACT_SYNC : ACT_NONE;
                PH_SYNC,
                PH_COLLECT: action = reject ? ACT_CLEAR : ACT_NIBBLE;
                default:    action = ACT_POST;
            endcase
        end
    end

    // divider operands: pulse over 56 for sync, pulse plus a quarter period over period else
    always_comb
    begin
        if (action == ACT_SYNC)
        begin
            div_dividend = DIV_DW'(pulse_reg);
            div_divisor  = SYNC_TICKS;
        end
        else
        begin
            div_dividend = DIV_DW'(pulse_reg) + DIV_DW'(period_reg[PERIOD_W-1:2]);
            div_divisor  = period_reg;
        end
    end

    spfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        if (div_quo > NIB_MAX_Q)
            nib = NIB_TOP;
        else if (div_quo < NIB_MIN_Q)
            nib = '0;
        else
            nib = NIB_W'(div_quo - NIB_MIN_Q);
    end

    assign idx     = (phase_reg == PH_SYNC) ? '0 : count_reg[IW-1:0];
    assign idx_inc = CW'(idx) + 1'b1;

    // frame view with the nibble being stored this step
    generate
        for (genvar k = 0; k < FRAME_SLOTS; k++)
        begin : g_pack
            if (k < NIBBLES_PER_FRAME)
            begin : g_used
                assign packed_frame[NIB_W*k +: NIB_W] =
                    (idx == IW'(k)) ? nib : store_reg[k];
            end
            else
            begin : g_unused
                assign packed_frame[NIB_W*k +: NIB_W] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        period_next    = period_reg;
        out_code_next  = RC_PROGRESS;
        out_frame_next = '0;
        case (action)
            ACT_CLEAR:
            begin
                phase_next = PH_SEARCH;
                count_next = '0;
            end
            ACT_SYNC:
            begin
                period_next = div_quo[PERIOD_W-1:0];
                phase_next  = PH_SYNC;
                count_next  = '0;
            end
            ACT_NIBBLE:
            begin
                count_next = idx_inc;
                if (idx_inc >= CW'(NIBBLES_PER_FRAME))
                begin
                    phase_next     = PH_DONE;
                    out_code_next  = RC_FRAME;
                    out_frame_next = packed_frame;
                end
                else
                    phase_next = PH_COLLECT;
            end
            ACT_POST:
            begin
                phase_next    = PH_SEARCH;
                count_next    = '0;
                out_code_next = RC_POST;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg      <= IDLE_RESET;
            period_reg    <= PERIOD_RESET;
            phase_reg     <= PH_SEARCH;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                idle_reg <= cfg_data;
            if (cmd.commit)
            begin
                period_reg    <= period_next;
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= in_func;
            pulse_reg <= in_pulse;
        end
        if (cmd.commit)
        begin
            out_code_reg   <= out_code_next;
            out_frame_reg  <= out_frame_next;
            out_period_reg <= period_next;
            if (action == ACT_NIBBLE)
                store_reg[idx] <= nib;
        end
    end

    assign sts.needs_div = (action == ACT_SYNC) || (action == ACT_NIBBLE);
    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_code   = out_code_reg;
    assign out_frame  = out_frame_reg;
    assign out_period = out_period_reg;

endmodule

[hdl/spfd_ctrl.sv]
// ----------------------------------------------------------------------------
// spfd_ctrl
// sequencer: accept a request, classify it, run the divider if needed, commit result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spfd_ctrl
    import spfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.needs_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_RES;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_RES;
            end
            ST_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/sent_pulse_frame_decoder.sv]
// ----------------------------------------------------------------------------
// sent_pulse_frame_decoder
// decodes sent single-edge nibble frames from measured falling-edge intervals
// ----------------------------------------------------------------------------
//  channel   dir  tdata                         tuser
//  s_axis    in   [15:0] pulse_ticks            [0] func
//  m_axis    out  [27:0] frame_nibbles,         [1:0] result_code
//                 [38:28] tick_period
//  cfg       in   cfg_wr_data = idle_limit_ticks, written when cfg_wr_en
//
//  an item skips the divider on resync, idle pulse, missed sync, reject or
//  post-frame pulse, and uses the shared 17-step restoring divider otherwise
//  (sync period or nibble value)
//  one request is in work at a time; s_tready is high only while the sequencer
//  waits for a request, also while an earlier result still waits in the output
//  register; a stalled m_axis holds the finished result back before commit
//  reset clears the frame state, sets tick period 120 and idle limit 20000
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sent_pulse_frame_decoder_assert.svh"

module sent_pulse_frame_decoder
    import spfd_pkg::*;
#(
    parameter int NIBBLES_PER_FRAME = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] pulse_ticks
    input  logic        s_tuser,     // [0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [27:0] frame_nibbles, [38:28] tick_period
    output logic [1:0]  m_tuser,     // [1:0] result_code
    // idle limit register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    ctrl_cmd_t           cmd;
    ctrl_sts_t           sts;
    logic [FRAME_W-1:0]  frame;
    logic [PERIOD_W-1:0] period;

    // sequencer: owns the handshake on the request side
    spfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: frame state, checks, divider and output register
    spfd_dp #(
        .NIBBLES_PER_FRAME (NIBBLES_PER_FRAME)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_func    (s_tuser),
        .in_pulse   (s_tdata),
        .cfg_we     (cfg_wr_en),
        .cfg_data   (cfg_wr_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_code   (m_tuser),
        .out_frame  (frame),
        .out_period (period)
    );

    // pack result fields, top pad bit stays zero
    assign m_tdata = {1'b0, period, frame};

    // one request in work: the request side closes right after acceptance
    `SPFD_ASSERT_NXT(a_one_in_work, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "request accepted while another is in work")

    // frame bits are zero unless a frame completes
    `SPFD_ASSERT_IMP(a_frame_zero, clk, rst_n, m_tvalid && (m_tuser != RC_FRAME),
        m_tdata[27:0] == '0, "frame bits set without a complete frame")

    // result codes stay within the defined set
    `SPFD_ASSERT_IMP(a_code_set, clk, rst_n, m_tvalid,
        (m_tuser == RC_FRAME) || (m_tuser == RC_PROGRESS) || (m_tuser == RC_POST),
        "undefined result code")

    // a new result only comes out of a request in work
    `SPFD_ASSERT_IMP(a_result_source, clk, rst_n, $rose(m_tvalid), $past(!s_tready),
        "result appeared with no request in work")

endmodule
